// ----- rtl/fpte_pkg.sv -----
package fpte_pkg;

	// Default configuration of the object table.
	localparam int NUM_OBJECTS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed widths and limits.
	localparam int DATA_W      = 32;
	localparam int FRAME_W     = 15;
	localparam int NUM_COMP    = 5;
	localparam int NUM_TYPES   = 3;
	localparam int MAX_RESULTS = 16;
	localparam int K_W         = $clog2(MAX_RESULTS + 1);

	// Request codes.
	localparam logic [3:0] REQ_SET_LOC   = 4'd0;
	localparam logic [3:0] REQ_SET_SIZE  = 4'd1;
	localparam logic [3:0] REQ_SET_ALPHA = 4'd2;
	localparam logic [3:0] REQ_MOVE      = 4'd3;
	localparam logic [3:0] REQ_SCALE     = 4'd4;
	localparam logic [3:0] REQ_ALPHA_TO  = 4'd5;
	localparam logic [3:0] REQ_TICK      = 4'd6;
	localparam logic [3:0] REQ_STOP      = 4'd7;
	localparam logic [3:0] REQ_READ      = 4'd8;

	// Component slots inside an entry.
	localparam logic [2:0] COMP_X = 3'd0;
	localparam logic [2:0] COMP_Y = 3'd1;
	localparam logic [2:0] COMP_W = 3'd2;
	localparam logic [2:0] COMP_H = 3'd3;
	localparam logic [2:0] COMP_A = 3'd4;

	// Step types.
	localparam logic [1:0] STEP_MOVE  = 2'd0;
	localparam logic [1:0] STEP_SCALE = 2'd1;
	localparam logic [1:0] STEP_ALPHA = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_LOAD,
		ST_EXEC,
		ST_DIVS,
		ST_DIVW,
		ST_SMUL,
		ST_SACC,
		ST_SCLR,
		ST_WR,
		ST_EMIT,
		ST_NEXT
	} state_t;

	typedef struct packed {
		logic [3:0]         req_type;
		logic [3:0]         obj_index;
		logic signed [15:0] value_a;
		logic signed [15:0] value_b;
		logic signed [31:0] alpha_target;
		logic [14:0]        frame_count;
		logic [2:0]         stop_type_mask;
		logic               stop_all_objects;
		logic               stop_finish;
	} req_word_t;

	typedef struct packed {
		logic [3:0]         out_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] size_w;
		logic signed [31:0] size_h;
		logic signed [31:0] alpha_level;
		logic [2:0]         active_mask;
		logic               idle_tick;
		logic               last;
	} rsp_word_t;

	// One object: properties, increments and frames left per step type.
	typedef struct packed {
		logic [NUM_COMP-1:0][DATA_W-1:0]   prop;
		logic [NUM_COMP-1:0][DATA_W-1:0]   inc;
		logic [NUM_TYPES-1:0][FRAME_W-1:0] frames;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [FRAME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

	// Step type that owns a component.
	function automatic logic [1:0] comp_type(input logic [2:0] c);
		logic [1:0] t;
		if (c < COMP_W) begin
			t = STEP_MOVE;
		end else if (c < COMP_A) begin
			t = STEP_SCALE;
		end else begin
			t = STEP_ALPHA;
		end
		return t;
	endfunction

endpackage

// ----- rtl/fpte_chan_if.sv -----
interface fpte_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fpte_div.sv -----
module fpte_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fpte_pkg::div_req_t  dreq,
	output fpte_pkg::div_rsp_t  drsp
);

	localparam int CNT_W = $clog2(fpte_pkg::DATA_W + 1);

	logic [fpte_pkg::FRAME_W-1:0] rem_q;
	logic [fpte_pkg::DATA_W-1:0]  quo_q;
	logic [fpte_pkg::FRAME_W-1:0] div_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         neg_q;
	logic                         busy_q;
	logic                         done_q;

	logic [fpte_pkg::FRAME_W:0]   shifted;
	logic                         ge;

	// One restoring step per cycle on the magnitude.
	assign shifted = {rem_q, quo_q[fpte_pkg::DATA_W-1]};
	assign ge      = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (dreq.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(fpte_pkg::DATA_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			rem_q <= '0;
			quo_q <= dreq.dividend[fpte_pkg::DATA_W-1] ? -dreq.dividend : dreq.dividend;
			neg_q <= dreq.dividend[fpte_pkg::DATA_W-1];
			div_q <= dreq.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? fpte_pkg::FRAME_W'(shifted - {1'b0, div_q})
				: fpte_pkg::FRAME_W'(shifted);
			quo_q <= {quo_q[fpte_pkg::DATA_W-2:0], ge};
		end
	end

	// Truncating signed quotient.
	assign drsp.busy     = busy_q;
	assign drsp.done     = done_q;
	assign drsp.quotient = neg_q ? -quo_q : quo_q;

endmodule

// ----- rtl/fixed_point_tween_engine.sv -----
// Channel | Dir | Word         | Moves
// req     | in  | req_word_t   | one request word: set, to, tick, stop or read
// rsp     | out | rsp_word_t   | one object report word, last marks the end
//
// One request is handled at a time; req.ready is high only while idle.
// A to-request runs the divider once per divided component (one bit per
// cycle in the divider); stop and tick handle one object at a time.
// Object properties, increments and frames sit in one table memory with a registered read.
// Reset clears per-object valid and active flags; invalid entries read as zero.
// A stalled rsp holds the engine in its emit state until the previous word is taken.
module fixed_point_tween_engine #(
	parameter int NUM_OBJECTS = fpte_pkg::NUM_OBJECTS_DEF,
	parameter int FRAC_BITS   = fpte_pkg::FRAC_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	fpte_chan_if.sink          req,
	fpte_chan_if.source        rsp
);

	localparam int AW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
	localparam int DW = fpte_pkg::DATA_W;

	fpte_pkg::state_t    state_q, state_d;
	fpte_pkg::req_word_t rq_q;
	fpte_pkg::entry_t    ent_q, rd_q, tick_ent;
	fpte_pkg::entry_t    mem_q [NUM_OBJECTS];
	fpte_pkg::rsp_word_t rsp_q, emit_word;
	fpte_pkg::div_req_t  div_req;
	fpte_pkg::div_rsp_t  div_rsp;

	logic [NUM_OBJECTS-1:0]    vld_q, active_q, snap_q, snap_hi;
	logic [AW-1:0]             idx_q;
	logic [fpte_pkg::K_W-1:0]  k_q;
	logic [2:0]                comp_q, last_comp;
	logic [1:0]                ctype;
	logic [DW-1:0]             mul_s1, a_fix, b_fix, target;
	logic [fpte_pkg::FRAME_W-1:0] frames_eff;
	logic                      rsp_valid_q, emit_load, in_acc, ok, multi, is_tick, apply;

	assign in_acc  = req.valid && req.ready;
	assign ok      = 32'(req.data.obj_index) < NUM_OBJECTS;
	assign is_tick = rq_q.req_type == fpte_pkg::REQ_TICK;
	assign multi   = is_tick || (rq_q.req_type == fpte_pkg::REQ_STOP && rq_q.stop_all_objects);
	assign a_fix   = DW'(32'(rq_q.value_a) << FRAC_BITS);
	assign b_fix   = DW'(32'(rq_q.value_b) << FRAC_BITS);
	assign frames_eff = (rq_q.frame_count == '0) ? fpte_pkg::FRAME_W'(1) : rq_q.frame_count;
	assign ctype   = fpte_pkg::comp_type(comp_q);
	assign apply   = rq_q.stop_finish && rq_q.stop_type_mask[ctype]
		&& (ent_q.frames[ctype] != '0);
	assign snap_hi = (snap_q >> idx_q) >> 1;

	// Last component that a to-request divides.
	always_comb begin
		unique case (rq_q.req_type)
			fpte_pkg::REQ_MOVE:  last_comp = fpte_pkg::COMP_Y;
			fpte_pkg::REQ_SCALE: last_comp = fpte_pkg::COMP_H;
			default:             last_comp = fpte_pkg::COMP_A;
		endcase
	end

	always_comb begin
		unique case (comp_q)
			fpte_pkg::COMP_X, fpte_pkg::COMP_W: target = a_fix;
			fpte_pkg::COMP_Y, fpte_pkg::COMP_H: target = b_fix;
			default:                            target = rq_q.alpha_target;
		endcase
	end

	// One frame of every active step of the loaded object.
	always_comb begin
		tick_ent = ent_q;
		for (int c = 0; c < fpte_pkg::NUM_COMP; c++) begin
			if (ent_q.frames[fpte_pkg::comp_type(3'(c))] != '0) begin
				tick_ent.prop[c] = ent_q.prop[c] + ent_q.inc[c];
			end
		end
		for (int t = 0; t < fpte_pkg::NUM_TYPES; t++) begin
			if (ent_q.frames[t] != '0) begin
				tick_ent.frames[t] = ent_q.frames[t] - 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpte_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (req.data.req_type)
						fpte_pkg::REQ_TICK:
							state_d = (active_q == '0) ? fpte_pkg::ST_EMIT : fpte_pkg::ST_RD;
						fpte_pkg::REQ_READ:
							state_d = ok ? fpte_pkg::ST_RD : fpte_pkg::ST_EMIT;
						fpte_pkg::REQ_STOP:
							state_d = (req.data.stop_all_objects || ok)
								? fpte_pkg::ST_RD : fpte_pkg::ST_IDLE;
						fpte_pkg::REQ_SET_LOC, fpte_pkg::REQ_SET_SIZE,
						fpte_pkg::REQ_SET_ALPHA, fpte_pkg::REQ_MOVE,
						fpte_pkg::REQ_SCALE, fpte_pkg::REQ_ALPHA_TO:
							state_d = ok ? fpte_pkg::ST_RD : fpte_pkg::ST_IDLE;
						default: state_d = fpte_pkg::ST_IDLE;
					endcase
				end
			end
			fpte_pkg::ST_RD:   state_d = fpte_pkg::ST_LOAD;
			fpte_pkg::ST_LOAD: state_d = fpte_pkg::ST_EXEC;
			fpte_pkg::ST_EXEC: begin
				unique case (rq_q.req_type)
					fpte_pkg::REQ_MOVE, fpte_pkg::REQ_SCALE, fpte_pkg::REQ_ALPHA_TO:
						state_d = fpte_pkg::ST_DIVS;
					fpte_pkg::REQ_TICK:
						state_d = (ent_q.frames == '0) ? fpte_pkg::ST_NEXT : fpte_pkg::ST_WR;
					fpte_pkg::REQ_STOP: state_d = fpte_pkg::ST_SMUL;
					fpte_pkg::REQ_READ: state_d = fpte_pkg::ST_EMIT;
					default:            state_d = fpte_pkg::ST_WR;
				endcase
			end
			fpte_pkg::ST_DIVS: state_d = fpte_pkg::ST_DIVW;
			fpte_pkg::ST_DIVW: begin
				if (div_rsp.done) begin
					state_d = (comp_q == last_comp) ? fpte_pkg::ST_WR : fpte_pkg::ST_DIVS;
				end
			end
			fpte_pkg::ST_SMUL: begin
				if (apply) begin
					state_d = fpte_pkg::ST_SACC;
				end else if (comp_q == fpte_pkg::COMP_A) begin
					state_d = fpte_pkg::ST_SCLR;
				end
			end
			fpte_pkg::ST_SACC:
				state_d = (comp_q == fpte_pkg::COMP_A) ? fpte_pkg::ST_SCLR : fpte_pkg::ST_SMUL;
			fpte_pkg::ST_SCLR: state_d = fpte_pkg::ST_WR;
			fpte_pkg::ST_WR: begin
				state_d = (is_tick && k_q < fpte_pkg::K_W'(fpte_pkg::MAX_RESULTS))
					? fpte_pkg::ST_EMIT : fpte_pkg::ST_NEXT;
			end
			fpte_pkg::ST_EMIT: begin
				if (emit_load) begin
					state_d = (is_tick && snap_q != '0) ? fpte_pkg::ST_NEXT : fpte_pkg::ST_IDLE;
				end
			end
			fpte_pkg::ST_NEXT: begin
				state_d = (multi && idx_q != AW'(NUM_OBJECTS - 1))
					? fpte_pkg::ST_RD : fpte_pkg::ST_IDLE;
			end
			default: state_d = fpte_pkg::ST_IDLE;
		endcase
	end

	// Handshake and unit controls.
	always_comb begin
		req.ready        = state_q == fpte_pkg::ST_IDLE;
		emit_load        = (state_q == fpte_pkg::ST_EMIT) && (!rsp_valid_q || rsp.ready);
		div_req.start    = state_q == fpte_pkg::ST_DIVS;
		div_req.dividend = target - ent_q.prop[comp_q];
		div_req.divisor  = frames_eff;
	end

	// Report word for the current object, or the idle word.
	always_comb begin
		emit_word             = '0;
		emit_word.pos_x       = ent_q.prop[fpte_pkg::COMP_X];
		emit_word.pos_y       = ent_q.prop[fpte_pkg::COMP_Y];
		emit_word.size_w      = ent_q.prop[fpte_pkg::COMP_W];
		emit_word.size_h      = ent_q.prop[fpte_pkg::COMP_H];
		emit_word.alpha_level = ent_q.prop[fpte_pkg::COMP_A];
		for (int t = 0; t < fpte_pkg::NUM_TYPES; t++) begin
			emit_word.active_mask[t] = ent_q.frames[t] != '0;
		end
		emit_word.last = 1'b1;
		if (is_tick) begin
			if (snap_q == '0) begin
				emit_word           = '0;
				emit_word.idle_tick = 1'b1;
				emit_word.last      = 1'b1;
			end else begin
				emit_word.out_index = 4'(idx_q);
				emit_word.last = (k_q == fpte_pkg::K_W'(fpte_pkg::MAX_RESULTS - 1))
					|| (snap_hi == '0);
			end
		end else begin
			emit_word.out_index = rq_q.obj_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpte_pkg::ST_IDLE;
			vld_q       <= '0;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fpte_pkg::ST_WR) begin
				vld_q[idx_q]    <= 1'b1;
				active_q[idx_q] <= ent_q.frames != '0;
			end
			if (emit_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Table memory with registered read.
	always_ff @(posedge clk) begin
		rd_q <= mem_q[idx_q];
		if (state_q == fpte_pkg::ST_WR) begin
			mem_q[idx_q] <= ent_q;
		end
	end

	// Working copy of the entry and sequencing registers.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			rsp_q <= emit_word;
		end
		unique case (state_q)
			fpte_pkg::ST_IDLE: begin
				if (in_acc) begin
					rq_q   <= req.data;
					snap_q <= active_q;
					ent_q  <= '0;
					k_q    <= '0;
					idx_q  <= (req.data.req_type == fpte_pkg::REQ_TICK
						|| (req.data.req_type == fpte_pkg::REQ_STOP
						&& req.data.stop_all_objects)) ? '0 : AW'(req.data.obj_index);
				end
			end
			fpte_pkg::ST_LOAD: ent_q <= vld_q[idx_q] ? rd_q : '0;
			fpte_pkg::ST_EXEC: begin
				// First component that a to-request or a stop walks.
				unique case (rq_q.req_type)
					fpte_pkg::REQ_SCALE:    comp_q <= fpte_pkg::COMP_W;
					fpte_pkg::REQ_ALPHA_TO: comp_q <= fpte_pkg::COMP_A;
					default:                comp_q <= fpte_pkg::COMP_X;
				endcase
				unique case (rq_q.req_type)
					fpte_pkg::REQ_SET_LOC: begin
						ent_q.prop[fpte_pkg::COMP_X] <= a_fix;
						ent_q.prop[fpte_pkg::COMP_Y] <= b_fix;
					end
					fpte_pkg::REQ_SET_SIZE: begin
						ent_q.prop[fpte_pkg::COMP_W] <= a_fix;
						ent_q.prop[fpte_pkg::COMP_H] <= b_fix;
					end
					fpte_pkg::REQ_SET_ALPHA: ent_q.prop[fpte_pkg::COMP_A] <= a_fix;
					fpte_pkg::REQ_TICK:      ent_q <= tick_ent;
					default: ;
				endcase
			end
			fpte_pkg::ST_DIVW: begin
				if (div_rsp.done) begin
					ent_q.inc[comp_q] <= div_rsp.quotient;
					if (comp_q == last_comp) begin
						ent_q.frames[ctype] <= frames_eff;
					end else begin
						comp_q <= comp_q + 1'b1;
					end
				end
			end
			fpte_pkg::ST_SMUL: begin
				mul_s1 <= DW'(ent_q.inc[comp_q] * DW'(ent_q.frames[ctype]));
				if (!apply && comp_q != fpte_pkg::COMP_A) begin
					comp_q <= comp_q + 1'b1;
				end
			end
			fpte_pkg::ST_SACC: begin
				ent_q.prop[comp_q] <= ent_q.prop[comp_q] + mul_s1;
				if (comp_q != fpte_pkg::COMP_A) begin
					comp_q <= comp_q + 1'b1;
				end
			end
			fpte_pkg::ST_SCLR: begin
				for (int t = 0; t < fpte_pkg::NUM_TYPES; t++) begin
					if (rq_q.stop_type_mask[t]) begin
						ent_q.frames[t] <= '0;
					end
				end
			end
			fpte_pkg::ST_EMIT: begin
				if (emit_load) begin
					k_q <= k_q + 1'b1;
				end
			end
			fpte_pkg::ST_NEXT: begin
				if (multi && idx_q != AW'(NUM_OBJECTS - 1)) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	fpte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (div_req),
		.drsp   (div_rsp)
	);

	// The divider runs only while the sequencer waits for it.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> state_q == fpte_pkg::ST_DIVW)
		else $error("divider busy outside its wait state");

	// No more than the result limit is reported per tick.
	a_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && is_tick |-> k_q < fpte_pkg::K_W'(fpte_pkg::MAX_RESULTS))
		else $error("tick report beyond result limit");

	// Active flags follow the frames written back.
	a_active_track: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fpte_pkg::ST_WR |=> active_q[$past(idx_q)] == ($past(ent_q.frames) != '0))
		else $error("active flag out of step with table");

endmodule

// ----- dv/fixed_point_tween_engine_tb.sv -----
module fixed_point_tween_engine_tb;

	localparam int OBJS = fpte_pkg::NUM_OBJECTS_DEF;
	localparam logic [3:0] REQ_UNKNOWN = 4'hF;

	logic clk;
	logic arst_n;

	fpte_chan_if #(.T(fpte_pkg::req_word_t)) req ();
	fpte_chan_if #(.T(fpte_pkg::rsp_word_t)) rsp ();

	fixed_point_tween_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Object table mirror: properties, increments and frames left per step type.
	logic [31:0] px [OBJS], py [OBJS], pw [OBJS], ph [OBJS], pa [OBJS];
	logic [31:0] ix [OBJS], iy [OBJS], iw [OBJS], ih [OBJS], ia [OBJS];
	logic [14:0] left [OBJS][3];

	fpte_pkg::rsp_word_t reports_due [$];
	int                  errors;
	bit                  calm;
	bit                  typed_pending;
	fpte_pkg::rsp_word_t typed_word;

	typedef struct {
		fpte_pkg::req_word_t w;
		bit                  typed;
		fpte_pkg::rsp_word_t exp;
	} row_t;

	// Clock and run timeout.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [2:0] steps_of(input int o);
		logic [2:0] m;
		m = '0;
		for (int t = 0; t < 3; t++) begin
			if (left[o][t] != 0) m[t] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [31:0] per_frame(input logic [31:0] target, input logic [31:0] cur,
			input logic [14:0] frames);
		int d;
		int f;
		d = int'(target - cur);
		f = int'({17'b0, frames});
		return 32'(d / f);
	endfunction

	function automatic fpte_pkg::rsp_word_t report_of(input int o);
		fpte_pkg::rsp_word_t r;
		r = '0;
		r.out_index = 4'(o);
		r.pos_x = px[o];
		r.pos_y = py[o];
		r.size_w = pw[o];
		r.size_h = ph[o];
		r.alpha_level = pa[o];
		r.active_mask = steps_of(o);
		return r;
	endfunction

	// Clear the selected steps of one object, optionally jumping to their end.
	task automatic halt_steps(input int o, input logic [2:0] tmask, input logic fin);
		logic [31:0] n;
		for (int t = 0; t < 3; t++) begin
			if (tmask[t] && left[o][t] != 0) begin
				n = {17'b0, left[o][t]};
				if (fin) begin
					if (t == 0) begin
						px[o] += ix[o] * n;
						py[o] += iy[o] * n;
					end else if (t == 1) begin
						pw[o] += iw[o] * n;
						ph[o] += ih[o] * n;
					end else begin
						pa[o] += ia[o] * n;
					end
				end
				left[o][t] = '0;
			end
		end
	endtask

	// Apply one request word to the mirror and queue the reports it causes.
	task automatic tween_apply(input fpte_pkg::req_word_t w);
		int                  o;
		int                  k;
		logic [31:0]         a;
		logic [31:0]         b;
		logic [14:0]         frames;
		fpte_pkg::rsp_word_t r;
		fpte_pkg::rsp_word_t made [$];
		o = int'(w.obj_index);
		a = {w.value_a, 16'b0};
		b = {w.value_b, 16'b0};
		frames = (w.frame_count == 0) ? 15'd1 : w.frame_count;
		k = 0;
		case (w.req_type)
			fpte_pkg::REQ_SET_LOC: begin
				px[o] = a;
				py[o] = b;
			end
			fpte_pkg::REQ_SET_SIZE: begin
				pw[o] = a;
				ph[o] = b;
			end
			fpte_pkg::REQ_SET_ALPHA: pa[o] = a;
			fpte_pkg::REQ_MOVE: begin
				ix[o] = per_frame(a, px[o], frames);
				iy[o] = per_frame(b, py[o], frames);
				left[o][0] = frames;
			end
			fpte_pkg::REQ_SCALE: begin
				iw[o] = per_frame(a, pw[o], frames);
				ih[o] = per_frame(b, ph[o], frames);
				left[o][1] = frames;
			end
			fpte_pkg::REQ_ALPHA_TO: begin
				ia[o] = per_frame(w.alpha_target, pa[o], frames);
				left[o][2] = frames;
			end
			fpte_pkg::REQ_TICK: begin
				for (int i = 0; i < OBJS; i++) begin
					if (steps_of(i) != 0) begin
						if (left[i][0] != 0) begin
							px[i] += ix[i];
							py[i] += iy[i];
							left[i][0] = left[i][0] - 15'd1;
						end
						if (left[i][1] != 0) begin
							pw[i] += iw[i];
							ph[i] += ih[i];
							left[i][1] = left[i][1] - 15'd1;
						end
						if (left[i][2] != 0) begin
							pa[i] += ia[i];
							left[i][2] = left[i][2] - 15'd1;
						end
						if (k < fpte_pkg::MAX_RESULTS) begin
							made.push_back(report_of(i));
							k++;
						end
					end
				end
				if (k == 0) begin
					r = '0;
					r.idle_tick = 1'b1;
					made.push_back(r);
				end
				made[made.size() - 1].last = 1'b1;
			end
			fpte_pkg::REQ_STOP: begin
				if (w.stop_all_objects) begin
					for (int i = 0; i < OBJS; i++) halt_steps(i, w.stop_type_mask, w.stop_finish);
				end else begin
					halt_steps(o, w.stop_type_mask, w.stop_finish);
				end
			end
			fpte_pkg::REQ_READ: begin
				r = report_of(o);
				r.last = 1'b1;
				made.push_back(r);
			end
			default: ;
		endcase
		// A typed-in expectation stands in for the mirror's own report.
		if (typed_pending && made.size() != 0) begin
			made.delete();
			made.push_back(typed_word);
		end
		foreach (made[j]) reports_due.push_back(made[j]);
	endtask

	// Track accepted request words.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) tween_apply(req.data);
	end

	task automatic field_check(input string name, input logic [31:0] e, input logic [31:0] g);
		if (e !== g) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, g);
			errors++;
		end
	endtask

	// Compare each report word with the oldest one due.
	always @(posedge clk) begin
		fpte_pkg::rsp_word_t e;
		fpte_pkg::rsp_word_t g;
		if (arst_n && rsp.valid && rsp.ready) begin
			g = rsp.data;
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected report word, expected none, actual %p", $time, g);
				errors++;
			end else begin
				e = reports_due.pop_front();
				field_check("out_index", 32'(e.out_index), 32'(g.out_index));
				field_check("pos_x", e.pos_x, g.pos_x);
				field_check("pos_y", e.pos_y, g.pos_y);
				field_check("size_w", e.size_w, g.size_w);
				field_check("size_h", e.size_h, g.size_h);
				field_check("alpha_level", e.alpha_level, g.alpha_level);
				field_check("active_mask", 32'(e.active_mask), 32'(g.active_mask));
				field_check("idle_tick", 32'(e.idle_tick), 32'(g.idle_tick));
				field_check("last", 32'(e.last), 32'(g.last));
			end
		end
	end

	// Receiver stalls in random bursts until the calm tail of the run.
	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 8);
				rsp.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end
		end
	end

	// Offer one word and hold it until it is taken; a typed expectation travels with it.
	task automatic send(input fpte_pkg::req_word_t w, input bit typed,
			input fpte_pkg::rsp_word_t exp);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= w;
		typed_pending <= typed;
		typed_word <= exp;
		do @(posedge clk); while (!req.ready);
	endtask

	function automatic fpte_pkg::req_word_t random_word();
		fpte_pkg::req_word_t w;
		int                  pick;
		w.req_type = 4'($urandom);
		w.obj_index = 4'($urandom);
		w.value_a = 16'($urandom);
		w.value_b = 16'($urandom);
		w.alpha_target = $urandom;
		w.stop_type_mask = 3'($urandom);
		w.stop_all_objects = 1'($urandom_range(0, 3) == 0);
		w.stop_finish = 1'($urandom);
		// Short steps mostly, so that they run out and retire.
		pick = $urandom_range(0, 19);
		if (pick == 0) w.frame_count = 15'($urandom);
		else if (pick == 1) w.frame_count = '0;
		else w.frame_count = 15'($urandom_range(1, 8));
		if (pick == 2) w.obj_index = 4'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 25) w.req_type = fpte_pkg::REQ_TICK;
		else if (pick < 33) w.req_type = fpte_pkg::REQ_SET_LOC;
		else if (pick < 40) w.req_type = fpte_pkg::REQ_SET_SIZE;
		else if (pick < 45) w.req_type = fpte_pkg::REQ_SET_ALPHA;
		else if (pick < 55) w.req_type = fpte_pkg::REQ_MOVE;
		else if (pick < 63) w.req_type = fpte_pkg::REQ_SCALE;
		else if (pick < 71) w.req_type = fpte_pkg::REQ_ALPHA_TO;
		else if (pick < 80) w.req_type = fpte_pkg::REQ_STOP;
		else if (pick < 95) w.req_type = fpte_pkg::REQ_READ;
		else w.req_type = 4'($urandom_range(9, 15));
		return w;
	endfunction

	function automatic row_t mk(input logic [3:0] rt, input int o, input int a, input int b,
			input int at, input int fr, input int tm, input bit all, input bit fin);
		row_t r;
		r.w = '{req_type: rt, obj_index: 4'(o), value_a: 16'(a), value_b: 16'(b),
			alpha_target: 32'(at), frame_count: 15'(fr), stop_type_mask: 3'(tm),
			stop_all_objects: all, stop_finish: fin};
		r.typed = 1'b0;
		r.exp = '0;
		return r;
	endfunction

	function automatic row_t mk_typed(input row_t r, input int o, input bit idle);
		r.typed = 1'b1;
		r.exp = '0;
		r.exp.out_index = 4'(o);
		r.exp.idle_tick = idle;
		r.exp.last = 1'b1;
		return r;
	endfunction

	// Stimulus.
	initial begin
		row_t rows [$];
		int   waited;
		errors = 0;
		calm = 1'b0;
		typed_pending = 1'b0;
		typed_word = '0;
		for (int i = 0; i < OBJS; i++) begin
			px[i] = '0; py[i] = '0; pw[i] = '0; ph[i] = '0; pa[i] = '0;
			ix[i] = '0; iy[i] = '0; iw[i] = '0; ih[i] = '0; ia[i] = '0;
			for (int t = 0; t < 3; t++) left[i][t] = '0;
		end
		req.valid = 1'b0;
		req.data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: reset state, extremes, each request kind and the corner cases.
		rows.push_back(mk_typed(mk(fpte_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0));
		rows.push_back(mk_typed(mk(fpte_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 0, 1));
		rows.push_back(mk(fpte_pkg::REQ_SET_LOC, 1, 32767, -32768, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_SET_SIZE, 1, -1, 1, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_SET_ALPHA, 1, 127, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_MOVE, 1, -32768, 32767, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_SCALE, 1, 100, -100, 0, 32767, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_ALPHA_TO, 1, 0, 0, 32'h8000_0000, 3, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk_typed(mk(fpte_pkg::REQ_READ, 15, 0, 0, 0, 0, 0, 0, 0), 15, 0));
		rows.push_back(mk(fpte_pkg::REQ_MOVE, 15, 5, -5, 0, 5, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_STOP, 1, 0, 0, 0, 0, 0, 0, 1));
		rows.push_back(mk(fpte_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_STOP, 1, 0, 0, 0, 0, 2, 0, 1));
		rows.push_back(mk(fpte_pkg::REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_STOP, 3, 0, 0, 0, 0, 7, 1, 0));
		rows.push_back(mk_typed(mk(fpte_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 0, 1));
		rows.push_back(mk(REQ_UNKNOWN, 15, -1, -1, -1, 32767, 7, 1, 1));
		rows.push_back(mk(fpte_pkg::REQ_ALPHA_TO, 2, 0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_MOVE, 0, -32768, -32768, 0, 4, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(fpte_pkg::REQ_STOP, 9, 0, 0, 0, 0, 7, 1, 1));
		rows.push_back(mk(fpte_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		foreach (rows[i]) begin
			send(rows[i].w, rows[i].typed, rows[i].exp);
		end

		// Random requests; the tail runs without idling.
		for (int n = 0; n < 106; n++) begin
			if (n == 80) calm = 1'b1;
			send(random_word(), 1'b0, '0);
		end
		req.valid <= 1'b0;

		waited = 0;
		while (reports_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && reports_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/fpte_pkg.sv
rtl/fpte_chan_if.sv
rtl/fpte_div.sv
rtl/fixed_point_tween_engine.sv
dv/fixed_point_tween_engine_tb.sv
